@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/gae_pkg.sv @@
`default_nettype none

package gae_pkg;

  localparam int CMD_W      = 2;
  localparam int GID_W      = 32;
  localparam int SAMPLE_W   = 32;
  localparam int VALUE_W    = 64;
  localparam int MODE_W     = 2;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int EPOCH_W    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SUM   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MAX   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LIMIT = 1'b1;

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_SUM;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = {{(EPOCH_W-1){1'b0}}, 1'b1};
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam logic [VALUE_W-1:0] MIN_IDENT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VALUE_W-1:0] MAX_IDENT = 64'hFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACC   = 2'd1,
    OP_READ  = 2'd2
  } gae_op_e;

  typedef struct packed {
    gae_op_e               op;
    logic                  in_range;
    logic [GID_W-1:0]      group_id;
    logic [SAMPLE_W-1:0]   sample_value;
  } gae_item_t;

  function automatic logic [VALUE_W-1:0] identity_of(input logic [MODE_W-1:0] mode);
    logic [VALUE_W-1:0] ident;
    case (mode)
      MODE_MIN: ident = MIN_IDENT;
      MODE_MAX: ident = MAX_IDENT;
      default:  ident = '0;
    endcase
    return ident;
  endfunction

endpackage

`default_nettype wire

@@ sv/gae_if.sv @@
`default_nettype none

interface gae_in_if;
  import gae_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [GID_W-1:0]    group_id;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output cmd, output group_id, output sample_value,
                  input ready);
  modport sink (input valid, input cmd, input group_id, input sample_value,
                output ready);
endinterface

interface gae_out_if;
  import gae_pkg::*;

  logic               valid;
  logic               ready;
  logic [GID_W-1:0]   result_group;
  logic [VALUE_W-1:0] result_value;
  logic               id_out_of_range;

  modport source (output valid, output result_group, output result_value,
                  output id_out_of_range, input ready);
  modport sink (input valid, input result_group, input result_value,
                input id_out_of_range, output ready);
endinterface

`default_nettype wire

@@ sv/gae_front.sv @@
`default_nettype none

module gae_front #(
  parameter int GROUP_CAPACITY = 1024
) (
  gae_in_if.sink                        req_i,
  input  logic [gae_pkg::LIMIT_W-1:0]   group_limit_i,
  input  logic                          q_full_i,
  input  logic                          clearing_i,
  output logic                          push_o,
  output gae_pkg::gae_item_t            item_o
);
  import gae_pkg::*;

  logic in_range;
  logic keep;

  assign in_range = (req_i.group_id < {{(GID_W-LIMIT_W){1'b0}}, group_limit_i}) &&
                    (req_i.group_id < GID_W'(GROUP_CAPACITY));

  always_comb begin
    item_o.op           = OP_START;
    item_o.in_range     = in_range;
    item_o.group_id     = req_i.group_id;
    item_o.sample_value = req_i.sample_value;
    keep                = 1'b0;
    case (req_i.cmd)
      CMD_START: begin
        item_o.op = OP_START;
        keep      = 1'b1;
      end
      CMD_ACC: begin
        // Accumulates outside the limit have no effect and are dropped here.
        item_o.op = OP_ACC;
        keep      = in_range;
      end
      CMD_READ: begin
        item_o.op = OP_READ;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req_i.ready = !q_full_i && !clearing_i;
  assign push_o      = req_i.valid && req_i.ready && keep;

endmodule

`default_nettype wire

@@ sv/gae_queue.sv @@
`default_nettype none

module gae_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gae_pkg::gae_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output gae_pkg::gae_item_t head_o
);
  import gae_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  gae_item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/gae_back.sv @@
`default_nettype none

module gae_back #(
  parameter int GROUP_CAPACITY = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gae_pkg::MODE_W-1:0]   agg_mode_i,
  input  logic                         q_valid_i,
  input  gae_pkg::gae_item_t           q_item_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  gae_out_if.source                    res_o
);
  import gae_pkg::*;

  localparam int ADDR_W = (GROUP_CAPACITY > 1) ? $clog2(GROUP_CAPACITY) : 1;
  localparam int WORD_W = EPOCH_W + VALUE_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GROUP_CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } gae_state_e;

  gae_state_e           state_q, state_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  gae_item_t            cur_q, cur_d;

  logic [WORD_W-1:0]    mem [GROUP_CAPACITY];
  logic [WORD_W-1:0]    rd_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;

  logic                 hit;
  logic [VALUE_W-1:0]   cur_val;
  logic [VALUE_W-1:0]   sample_ext;
  logic [VALUE_W-1:0]   new_val;
  logic [VALUE_W-1:0]   read_val;
  logic                 res_load;

  logic                 res_valid_q;
  logic [GID_W-1:0]     res_group_q;
  logic [VALUE_W-1:0]   res_value_q;
  logic                 res_oor_q;

  // The entry belongs to the current batch only if its tag matches the epoch.
  assign hit        = (rd_q[WORD_W-1:VALUE_W] == epoch_q);
  assign cur_val    = hit ? rd_q[VALUE_W-1:0] : identity_of(agg_mode_i);
  assign sample_ext = {{(VALUE_W-SAMPLE_W){cur_q.sample_value[SAMPLE_W-1]}},
                       cur_q.sample_value};
  assign read_val   = cur_q.in_range ? cur_val : '0;

  always_comb begin
    case (agg_mode_i)
      MODE_SUM:   new_val = cur_val + sample_ext;
      MODE_COUNT: new_val = cur_val + VALUE_W'(1);
      MODE_MIN:   new_val = ($signed(sample_ext) < $signed(cur_val)) ? sample_ext : cur_val;
      MODE_MAX:   new_val = ($signed(cur_val) < $signed(sample_ext)) ? sample_ext : cur_val;
      default:    new_val = cur_val;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_q.group_id[ADDR_W-1:0];
    mem_wdata = {epoch_q, new_val};
    mem_re    = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          cur_d = q_item_i;
          case (q_item_i.op)
            OP_START: begin
              // Once the epochs run out, all tags are cleared before reuse.
              if (epoch_q == EPOCH_LAST) begin
                epoch_d = EPOCH_FIRST;
                state_d = ST_CLEAR;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end
            OP_ACC: begin
              mem_re  = 1'b1;
              state_d = ST_EXEC;
            end
            OP_READ: begin
              mem_re  = q_item_i.in_range;
              state_d = ST_EXEC;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (cur_q.op == OP_ACC) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      epoch_q     <= EPOCH_FIRST;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      clr_q   <= clr_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (res_load) begin
      res_group_q <= cur_q.group_id;
      res_value_q <= read_val;
      res_oor_q   <= !cur_q.in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[q_item_i.group_id[ADDR_W-1:0]];
    end
  end

  assign clearing_o            = (state_q == ST_CLEAR);
  assign res_o.valid           = res_valid_q;
  assign res_o.result_group    = res_group_q;
  assign res_o.result_value    = res_value_q;
  assign res_o.id_out_of_range = res_oor_q;

endmodule

`default_nettype wire

@@ sv/grouped_aggregate_engine.sv @@
// A read request passes the request queue, the table read and the result register in that order,
// and its result waits in the result register while the output is stalled. An accumulate or a
// read goes through a table read and then the update or the result on the execution side, which
// takes no new item until it is through with the last. Every 255th start adds a tag clearing pass
// over all GROUP_CAPACITY table entries. Reset: asynchronous, active low; afterwards a clearing pass
// over all GROUP_CAPACITY entries runs with the request channel not ready.
`default_nettype none

module grouped_aggregate_engine #(
  parameter int GROUP_CAPACITY = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gae_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gae_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  gae_in_if.sink                          req_i,
  gae_out_if.source                       res_o
);
  import gae_pkg::*;

  logic [MODE_W-1:0]  agg_mode_q;
  logic [LIMIT_W-1:0] group_limit_q;
  logic               push;
  gae_item_t          push_item;
  logic               q_full;
  logic               q_valid;
  gae_item_t          q_item;
  logic               pop;
  logic               clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_mode_q    <= MODE_RESET;
      group_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AGG_MODE:    agg_mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_GROUP_LIMIT: group_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gae_front #(
    .GROUP_CAPACITY(GROUP_CAPACITY)
  ) u_front (
    .req_i         (req_i),
    .group_limit_i (group_limit_q),
    .q_full_i      (q_full),
    .clearing_i    (clearing),
    .push_o        (push),
    .item_o        (push_item)
  );

  gae_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_item)
  );

  gae_back #(
    .GROUP_CAPACITY(GROUP_CAPACITY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .agg_mode_i (agg_mode_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

@@ sv/gae_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module gae_checker #(
  parameter int GROUP_CAPACITY = 1024
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [gae_pkg::GID_W-1:0]     res_group_i,
  input logic [gae_pkg::VALUE_W-1:0]   res_value_i,
  input logic                          res_oor_i
);
  import gae_pkg::*;

  `ASSERT_ALWAYS(a_no_request_during_clear, clk_i, !rst_ni |=> !req_ready_i, "request taken during reset clearing")

  `ASSERT_CLK(a_result_held, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_value_i) && $stable(res_group_i), "stalled result changed")

  `ASSERT_CLK(a_oor_value_zero, clk_i, rst_ni, res_valid_i && res_oor_i |-> res_value_i == '0, "out of range read has nonzero value")

  `ASSERT_CLK(a_in_range_below_capacity, clk_i, rst_ni, res_valid_i && !res_oor_i |-> res_group_i < GID_W'(GROUP_CAPACITY), "in range result beyond capacity")

endmodule

bind grouped_aggregate_engine gae_checker #(
  .GROUP_CAPACITY(GROUP_CAPACITY)
) u_gae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_group_i (res_o.result_group),
  .res_value_i (res_o.result_value),
  .res_oor_i   (res_o.id_out_of_range)
);

`default_nettype wire
